FILE: rtl/mdsl_pkg.sv
`timescale 1ns / 1ps

package mdsl_pkg;

  localparam int DUTY_FULL_SCALE = 10000;

  localparam int RST_MAX_DUTY   = DUTY_FULL_SCALE;
  localparam int RST_REAR_STEP  = 400;
  localparam int RST_STEER_STEP = 400;
  localparam int RST_DWELL      = 20;

  typedef logic        [13:0] duty_t;
  typedef logic signed [14:0] sduty_t;
  typedef logic signed [15:0] target_t;
  typedef logic        [15:0] dwell_t;

  typedef struct packed {
    target_t steer_target;
    target_t left_target;
    target_t right_target;
  } target_word_t;

  typedef struct packed {
    logic  steer_dir;
    duty_t steer_pwm;
    logic  left_dir;
    duty_t left_pwm;
    logic  right_dir;
    duty_t right_pwm;
  } duty_word_t;

  typedef enum logic [2:0] {
    REG_MAX_DUTY     = 3'd0,
    REG_REAR_STEP    = 3'd1,
    REG_STEER_STEP   = 3'd2,
    REG_DWELL_TICKS  = 3'd3,
    REG_SLEW_ENABLE  = 3'd4,
    REG_STEER_INVERT = 3'd5,
    REG_LEFT_INVERT  = 3'd6,
    REG_RIGHT_INVERT = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    duty_t  max_duty;
    duty_t  step;
    dwell_t dwell;
    logic   slew_en;
    logic   invert;
  } chan_cfg_t;

  // Clamp a signed 16 bit request to +-max; the result always fits 15 bits.
  function automatic sduty_t clamp_target(target_t t, duty_t m);
    logic signed [16:0] t_ext;
    logic signed [16:0] m_ext;
    sduty_t             r;
    t_ext = 17'(t);
    m_ext = signed'({3'b000, m});
    if (t_ext > m_ext) begin
      r = m_ext[14:0];
    end else if (t_ext < -m_ext) begin
      r = 15'(-m_ext);
    end else begin
      r = t_ext[14:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/mdsl_if.sv
`timescale 1ns / 1ps

interface mdsl_target_if;
  import mdsl_pkg::*;
  logic         valid;
  logic         ready;
  target_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mdsl_duty_if;
  import mdsl_pkg::*;
  logic       valid;
  logic       ready;
  duty_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mdsl_cfg_if;
  import mdsl_pkg::*;
  logic        valid;
  logic        ready;
  cfg_idx_t    index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/mdsl_chan.sv
`timescale 1ns / 1ps

module mdsl_chan (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  mdsl_pkg::sduty_t  target,
  input  mdsl_pkg::chan_cfg_t cfg,
  output logic              dir,
  output mdsl_pkg::duty_t   pwm
);
  import mdsl_pkg::*;

  sduty_t             applied;
  dwell_t             hold;
  sduty_t             applied_next;
  dwell_t             hold_next;

  logic               rev;
  logic               dwelling;
  logic               toward;
  sduty_t             t_eff;
  logic signed [16:0] a_ext;
  logic signed [16:0] t_ext;
  logic signed [16:0] up;
  logic signed [16:0] dn;
  logic signed [16:0] m_ext;
  logic signed [16:0] o_raw;
  logic signed [16:0] o;

  always_comb begin
    // A request of the opposite sign to what is applied goes through zero first.
    rev      = (target > 0 && applied < 0) || (target < 0 && applied > 0);
    t_eff    = rev ? '0 : target;
    dwelling = (applied == 0) && (hold != '0);
    toward   = (t_eff >= 0 && applied >= 0 && t_eff < applied) ||
               (t_eff <= 0 && applied <= 0 && t_eff > applied);
    a_ext    = 17'(applied);
    t_ext    = 17'(t_eff);
    up       = a_ext + signed'({3'b000, cfg.step});
    dn       = a_ext - signed'({3'b000, cfg.step});

    if (!cfg.slew_en) begin
      applied_next = target;
    end else if (dwelling) begin
      applied_next = '0;
    end else if (toward) begin
      applied_next = t_eff;
    end else if (t_eff > applied) begin
      applied_next = (up > t_ext) ? t_eff : up[14:0];
    end else if (t_eff < applied) begin
      applied_next = (dn < t_ext) ? t_eff : dn[14:0];
    end else begin
      applied_next = applied;
    end

    if (!cfg.slew_en) begin
      hold_next = hold;
    end else if (rev) begin
      hold_next = cfg.dwell;
    end else if (dwelling) begin
      hold_next = hold - 16'd1;
    end else begin
      hold_next = hold;
    end

    // The output is clamped again, since max_duty may have been lowered.
    m_ext = signed'({3'b000, cfg.max_duty});
    o_raw = cfg.invert ? -17'(applied_next) : 17'(applied_next);
    if (o_raw > m_ext) begin
      o = m_ext;
    end else if (o_raw < -m_ext) begin
      o = -m_ext;
    end else begin
      o = o_raw;
    end
    dir = (o >= 0);
    pwm = dir ? o[13:0] : 14'(-o);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      applied <= '0;
      hold    <= '0;
    end else if (load) begin
      applied <= applied_next;
      hold    <= hold_next;
    end
  end

endmodule

FILE: rtl/motor_duty_slew_limiter_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Word                                         Handshake
// target    in   steer/left/right target, 16 bit signed       valid/ready
// duty      out  dir + 14 bit pwm for steer, left, right      valid/ready
// cfg       in   3 bit register index, 16 bit write data      valid/ready, always ready
//
// One word per cycle sustained while duty is ready; a taken word passes the first register, then the second, then duty.
// The first register holds the clamped targets, the second the slewed result; the
// per-channel slew state is updated as a word moves into the result register.
// A stall on duty holds both registers; target stays ready while either has room.
// Synchronous reset restores the register defaults and zeroes applied duty and dwell.

module motor_duty_slew_limiter_core (
  input logic          clk,
  input logic          rst,
  mdsl_target_if.sink  target,
  mdsl_duty_if.source  duty,
  mdsl_cfg_if.sink     cfg
);
  import mdsl_pkg::*;

  duty_t      max_duty;
  duty_t      rear_step;
  duty_t      steer_step;
  dwell_t     dwell_ticks;
  logic       slew_enable;
  logic       steer_invert;
  logic       left_invert;
  logic       right_invert;

  logic       s1_valid;
  sduty_t     s1_steer;
  sduty_t     s1_left;
  sduty_t     s1_right;
  logic       s1_move;

  logic       out_valid;
  duty_word_t out_word;
  duty_word_t res;

  chan_cfg_t  steer_cfg;
  chan_cfg_t  left_cfg;
  chan_cfg_t  right_cfg;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_duty     <= 14'(RST_MAX_DUTY);
      rear_step    <= 14'(RST_REAR_STEP);
      steer_step   <= 14'(RST_STEER_STEP);
      dwell_ticks  <= 16'(RST_DWELL);
      slew_enable  <= 1'b1;
      steer_invert <= 1'b0;
      left_invert  <= 1'b0;
      right_invert <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MAX_DUTY: begin
          max_duty <= (cfg.data[13:0] > 14'(DUTY_FULL_SCALE)) ?
                      14'(DUTY_FULL_SCALE) : cfg.data[13:0];
        end
        REG_REAR_STEP: begin
          rear_step <= (cfg.data[13:0] == '0) ? 14'd1 : cfg.data[13:0];
        end
        REG_STEER_STEP: begin
          steer_step <= (cfg.data[13:0] == '0) ? 14'd1 : cfg.data[13:0];
        end
        REG_DWELL_TICKS:  dwell_ticks  <= cfg.data;
        REG_SLEW_ENABLE:  slew_enable  <= cfg.data[0];
        REG_STEER_INVERT: steer_invert <= cfg.data[0];
        REG_LEFT_INVERT:  left_invert  <= cfg.data[0];
        REG_RIGHT_INVERT: right_invert <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign s1_move      = s1_valid && (!out_valid || duty.ready);
  assign target.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (target.valid && target.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (target.valid && target.ready) begin
      s1_steer <= clamp_target(target.data.steer_target, max_duty);
      s1_left  <= clamp_target(target.data.left_target, max_duty);
      s1_right <= clamp_target(target.data.right_target, max_duty);
    end
  end

  assign steer_cfg = '{max_duty: max_duty, step: steer_step, dwell: dwell_ticks,
                       slew_en: slew_enable, invert: steer_invert};
  assign left_cfg  = '{max_duty: max_duty, step: rear_step, dwell: dwell_ticks,
                       slew_en: slew_enable, invert: left_invert};
  assign right_cfg = '{max_duty: max_duty, step: rear_step, dwell: dwell_ticks,
                       slew_en: slew_enable, invert: right_invert};

  mdsl_chan u_steer (
    .clk    (clk),
    .rst    (rst),
    .load   (s1_move),
    .target (s1_steer),
    .cfg    (steer_cfg),
    .dir    (res.steer_dir),
    .pwm    (res.steer_pwm)
  );

  mdsl_chan u_left (
    .clk    (clk),
    .rst    (rst),
    .load   (s1_move),
    .target (s1_left),
    .cfg    (left_cfg),
    .dir    (res.left_dir),
    .pwm    (res.left_pwm)
  );

  mdsl_chan u_right (
    .clk    (clk),
    .rst    (rst),
    .load   (s1_move),
    .target (s1_right),
    .cfg    (right_cfg),
    .dir    (res.right_dir),
    .pwm    (res.right_pwm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (duty.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_word <= res;
    end
  end

  assign duty.valid = out_valid;
  assign duty.data  = out_word;

endmodule

FILE: rtl/mdsl_checker.sv
`timescale 1ns / 1ps

module mdsl_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input mdsl_pkg::duty_word_t out_word
);
  import mdsl_pkg::*;

  // A stalled result word must be held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("duty word changed while stalled");

  // The magnitude never exceeds the full scale limit.
  a_pwm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.steer_pwm <= 14'(DUTY_FULL_SCALE)) &&
                  (out_word.left_pwm <= 14'(DUTY_FULL_SCALE)) &&
                  (out_word.right_pwm <= 14'(DUTY_FULL_SCALE)))
    else $error("pwm magnitude above full scale");

  // A reverse direction pin only comes with a nonzero magnitude.
  a_dir_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.steer_dir || out_word.steer_pwm != '0) &&
                  (out_word.left_dir || out_word.left_pwm != '0) &&
                  (out_word.right_dir || out_word.right_pwm != '0))
    else $error("reverse direction with zero magnitude");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind motor_duty_slew_limiter_core mdsl_checker u_mdsl_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (duty.valid),
  .out_ready (duty.ready),
  .out_word  (duty.data)
);
